// File: src/nth_root_bisection_defines.svh
// Assertion macros shared by the nth-root bisection block.
`ifndef NTH_ROOT_BISECTION_DEFINES_SVH
`define NTH_ROOT_BISECTION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define NRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/nrb_pkg.sv
// Shared constants and codes for the nth-root bisection block.
package nrb_pkg;

	localparam int MAX_ITERATIONS_DEF = 48;
	localparam int MAX_INDEX_DEF      = 15;
	localparam int FRACTION_BITS_DEF  = 16;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 4;
	localparam int STAT_W  = 2;
	localparam int TOL_W   = 16;
	localparam int ADDR_W  = 3;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	// register indexes (word address)
	localparam logic REG_TOL = 1'b0;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_LIMIT   = 2'd2;

endpackage

// File: src/nrb_in_if.sv
// Input channel: radicand and root index words.
interface nrb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [nrb_pkg::DATA_W-1:0] radicand;
	logic [nrb_pkg::INDEX_W-1:0]       root_index;

	modport source (output valid, output radicand, output root_index, input ready);
	modport sink (input valid, input radicand, input root_index, output ready);
endinterface

// File: src/nrb_out_if.sv
// Output channel: root and status words.
interface nrb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [nrb_pkg::DATA_W-1:0] root;
	logic [nrb_pkg::STAT_W-1:0]        status;

	modport source (output valid, output root, output status, input ready);
	modport sink (input valid, input root, input status, output ready);
endinterface

// File: src/nth_root_bisection.sv
// Top level: index-th root of a signed fixed-point radicand by bisection.
// Each bisection step runs a midpoint state, passes on the shared 32x32 multiplier
// to form the root_index-th power, and a compare state. A valid word takes up to
// MAX_ITERATIONS steps; an invalid word goes straight from accept to result load.
// One word is worked at a time; a finished result may wait while the next is accepted.
// Reset (arst_n low, async): sequencer idle, no result pending, tolerance back to 7.
`include "nth_root_bisection_defines.svh"

module nth_root_bisection #(
	parameter int MAX_ITERATIONS = nrb_pkg::MAX_ITERATIONS_DEF,
	parameter int MAX_INDEX      = nrb_pkg::MAX_INDEX_DEF,
	parameter int FRACTION_BITS  = nrb_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nrb_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	nrb_in_if.sink                      req,
	nrb_out_if.source                   rsp
);

	localparam int DW     = nrb_pkg::DATA_W;
	localparam int IW     = nrb_pkg::INDEX_W;
	localparam int ITER_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
	localparam logic signed [DW:0] ONE = 33'sd1 <<< FRACTION_BITS;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MID  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                    state_q;
	logic [nrb_pkg::TOL_W-1:0]     tol_q;
	logic signed [DW-1:0]          rad_q, lo_q, hi_q, m_q;
	logic [IW-1:0]                 n_q, mcnt_q;
	logic [ITER_W-1:0]             iter_q;
	logic signed [2*DW-1:0]        prod_q;
	logic                          sat_q;
	logic signed [DW-1:0]          fin_root_q;
	logic [nrb_pkg::STAT_W-1:0]    fin_stat_q;
	logic                          out_valid_q;
	logic signed [DW-1:0]          out_root_q;
	logic [nrb_pkg::STAT_W-1:0]    out_stat_q;

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == nrb_pkg::REG_TOL) ? {16'd0, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= nrb_pkg::TOL_RESET;
		end else if (cfg_wr && paddr[2] == nrb_pkg::REG_TOL) begin
			tol_q <= pwdata[15:0];
		end
	end

	// input screening
	logic signed [DW:0] rad_in;
	logic               in_bad;
	logic               in_acc;
	assign rad_in = {req.radicand[DW-1], req.radicand};
	assign in_bad = (req.root_index < 4'd2) ||
		({28'd0, req.root_index} > 32'(MAX_INDEX)) ||
		(rad_in > -ONE && rad_in < ONE) ||
		(req.radicand[DW-1] && !req.root_index[0]);
	assign req.ready = (state_q == S_IDLE);
	assign in_acc = req.valid && req.ready;

	// midpoint, truncated toward zero
	logic signed [DW:0] sum, mid;
	assign sum = {lo_q[DW-1], lo_q} + {hi_q[DW-1], hi_q};
	assign mid = (sum + {{DW{1'b0}}, sum[DW]}) >>> 1;

	// floor shift and saturation of the last product
	logic signed [2*DW-1:0] shq;
	logic [DW:0]            upper;
	logic                   cur_sat;
	logic signed [DW-1:0]   pw;
	assign shq     = prod_q >>> FRACTION_BITS;
	assign upper   = shq[2*DW-1:DW-1];
	assign cur_sat = !((&upper) || (~|upper));
	assign pw      = cur_sat ? (shq[2*DW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : shq[DW-1:0];

	// shared multiplier: first pass squares the midpoint
	logic                   first_mul;
	logic signed [DW-1:0]   mul_a;
	logic signed [2*DW-1:0] mul_p;
	assign first_mul = (mcnt_q == 4'd1);
	assign mul_a     = first_mul ? m_q : pw;
	assign mul_p     = mul_a * m_q;

	// residual and decision
	logic signed [DW:0] res;
	logic [DW:0]        mag;
	logic               sat_all, rpos, rneg, rad_pos, to_lo, conv;
	assign sat_all = sat_q || cur_sat;
	assign res     = {pw[DW-1], pw} - {rad_q[DW-1], rad_q};
	assign mag     = res[DW] ? 33'(-res) : 33'(res);
	assign rpos    = sat_all ? !pw[DW-1] : (!res[DW] && res != 33'sd0);
	assign rneg    = sat_all ? pw[DW-1] : res[DW];
	assign rad_pos = !rad_q[DW-1];
	assign to_lo   = (rneg && rad_pos) || (rpos && !rad_pos);
	assign conv    = !sat_all && (mag <= {17'd0, tol_q});

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= in_bad ? S_DONE : S_MID;
				S_MID:  state_q <= S_MUL;
				S_MUL:  if (mcnt_q == n_q - 4'd1) state_q <= S_CMP;
				S_CMP:  state_q <= (conv || iter_q == ITER_LAST) ? S_DONE : S_MID;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rad_q      <= req.radicand;
				n_q        <= req.root_index;
				lo_q       <= '0;
				hi_q       <= req.radicand;
				iter_q     <= '0;
				fin_root_q <= '0;
				fin_stat_q <= nrb_pkg::ST_INVALID;
			end
			S_MID: begin
				m_q    <= mid[DW-1:0];
				mcnt_q <= 4'd1;
				sat_q  <= 1'b0;
			end
			S_MUL: begin
				prod_q <= mul_p;
				mcnt_q <= mcnt_q + 4'd1;
				if (!first_mul) sat_q <= sat_q || cur_sat;
			end
			S_CMP: begin
				if (rpos || rneg) begin
					if (to_lo) lo_q <= m_q;
					else hi_q <= m_q;
				end
				iter_q     <= iter_q + 1'b1;
				fin_root_q <= m_q;
				fin_stat_q <= conv ? nrb_pkg::ST_OK : nrb_pkg::ST_LIMIT;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_root_q <= fin_root_q;
			out_stat_q <= fin_stat_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.root   = out_root_q;
	assign rsp.status = out_stat_q;

	`NRB_ASSERT_NOW(a_mul_count, clk, arst_n, state_q == S_MUL, mcnt_q >= 4'd1 && mcnt_q < n_q, "multiply count out of range")
	`NRB_ASSERT_NEXT(a_cmp_next, clk, arst_n, state_q == S_CMP, state_q == S_MID || state_q == S_DONE, "bad step after compare")
	`NRB_ASSERT_NOW(a_invalid_zero, clk, arst_n, rsp.valid && rsp.status == nrb_pkg::ST_INVALID, rsp.root == 32'sd0, "invalid result with nonzero root")

endmodule

// File: tb/nth_root_bisection_tb.sv
// Self-checking testbench for the nth-root bisection block.
`timescale 1ns / 1ps

module nth_root_bisection_tb;

	localparam int     N_DIRECTED     = 21;
	localparam int     N_PHASES       = 6;
	localparam int     RANDOM_PER_PHASE = 135;
	localparam int     IDLE_WAIT      = 800;	// a full search at index 15 plus margin
	localparam int     HOLD_AT        = 300;	// result count that triggers the long hold-off
	localparam int     HOLD_CYCLES    = 4000;
	localparam longint CYCLE_LIMIT    = 4_000_000;
	localparam int     REPORT_MAX     = 10;
	localparam longint Q_ONE          = 64'sd1 << nrb_pkg::FRACTION_BITS_DEF;
	localparam longint Q_MAX          = 64'sd2147483647;
	localparam longint Q_MIN          = -64'sd2147483648;
	localparam logic [nrb_pkg::ADDR_W-1:0] TOL_ADDR =
		nrb_pkg::ADDR_W'({nrb_pkg::REG_TOL, 2'b00});

	typedef struct packed {
		logic signed [nrb_pkg::DATA_W-1:0] root;
		logic [nrb_pkg::STAT_W-1:0]        status;
	} root_word_t;

	typedef struct {
		logic signed [nrb_pkg::DATA_W-1:0] radicand;
		logic [nrb_pkg::INDEX_W-1:0]       index;
		bit                                fixed;	// expected word typed in below
		root_word_t                        want;
	} directed_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [nrb_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	nrb_in_if  req_if();
	nrb_out_if rsp_if();

	nth_root_bisection i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	root_word_t                pending_roots[$];
	logic [nrb_pkg::TOL_W-1:0] tol_setting;
	longint                    cycle_count;
	int                        mismatches;
	int                        words_sent;
	int                        words_back;
	int                        n_converged;
	int                        n_invalid;
	int                        n_limit;
	int                        send_quiet;
	int                        recv_quiet;
	bit                        hold_done;

	directed_t directed_rows [N_DIRECTED] = '{
		'{32'sh0004_0000, 4'd0,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},	// index below range
		'{32'sh0004_0000, 4'd1,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},
		'{32'sh0000_FFFF, 4'd2,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},	// just under one
		'{32'shFFFF_0001, 4'd3,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},	// just above minus one
		'{32'sh0000_0000, 4'd15, 1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},
		'{32'shFFFC_0000, 4'd2,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},	// even root of negative
		'{32'sh8000_0000, 4'd14, 1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},
		'{32'sh8000_0000, 4'd0,  1'b1, '{32'sd0, nrb_pkg::ST_INVALID}},
		'{32'sh0004_0000, 4'd2,  1'b1, '{32'sh0002_0000, nrb_pkg::ST_OK}},	// first midpoint exact
		'{32'sh0001_0000, 4'd2,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'shFFFF_0000, 4'd3,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'shFFFC_0000, 4'd3,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh7FFF_FFFF, 4'd2,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh7FFF_FFFF, 4'd15, 1'b0, '{32'sd0, nrb_pkg::ST_OK}},	// power saturates early
		'{32'sh8000_0000, 4'd3,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh8000_0000, 4'd15, 1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh0008_0000, 4'd3,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh0002_0000, 4'd14, 1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'shFFE0_0000, 4'd5,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'sh1234_5678, 4'd9,  1'b0, '{32'sd0, nrb_pkg::ST_OK}},
		'{32'shEDCB_A988, 4'd7,  1'b0, '{32'sd0, nrb_pkg::ST_OK}}
	};

	function automatic root_word_t bisect_root(
			input logic signed [nrb_pkg::DATA_W-1:0] rad_in,
			input logic [nrb_pkg::INDEX_W-1:0] idx,
			input logic [nrb_pkg::TOL_W-1:0] tol);
		longint     rad;
		longint     lo;
		longint     hi;
		longint     mid;
		longint     pw;
		longint     res;
		longint     mag;
		bit         sat;
		int         rsign;
		int         lsign;
		root_word_t w;
		rad = rad_in;
		w.root = '0;
		w.status = nrb_pkg::ST_INVALID;
		if (idx < 2 || idx > nrb_pkg::MAX_INDEX_DEF || (rad > -Q_ONE && rad < Q_ONE) ||
				(rad < 0 && !idx[0]))
			return w;
		lo = 0;
		hi = rad;
		mid = 0;
		w.status = nrb_pkg::ST_LIMIT;
		for (int step = 0; step < nrb_pkg::MAX_ITERATIONS_DEF; step++) begin
			mid = (lo + hi) / 2;
			pw = mid;
			sat = 0;
			for (int k = 1; k < int'(idx); k++) begin
				// arithmetic shift floors, matching the rounding toward minus infinity
				pw = (pw * mid) >>> nrb_pkg::FRACTION_BITS_DEF;
				if (pw > Q_MAX) begin
					pw = Q_MAX;
					sat = 1;
				end
				if (pw < Q_MIN) begin
					pw = Q_MIN;
					sat = 1;
				end
			end
			if (sat) begin
				rsign = (pw < 0) ? -1 : 1;
				res = 0;
			end else begin
				res = pw - rad;
				rsign = (res > 0) ? 1 : ((res < 0) ? -1 : 0);
			end
			if (rsign != 0) begin
				lsign = (rad > 0) ? -1 : 1;
				if (rsign == lsign)
					lo = mid;
				else
					hi = mid;
			end
			mag = (res < 0) ? -res : res;
			if (!sat && mag <= longint'(tol)) begin
				w.status = nrb_pkg::ST_OK;
				break;
			end
		end
		w.root = mid[nrb_pkg::DATA_W-1:0];
		return w;
	endfunction

	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endfunction

	function automatic int draw_gap(ref int quiet);
		int gap;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 24) == 0)
			quiet = $urandom_range(8, 30);
		return gap;
	endfunction

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_roots.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// one APB transfer; called and returns at a falling edge
	task automatic apb_cycle(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel = 1;
		penable = 0;
		pwrite = wr;
		paddr = TOL_ADDR;
		pwdata = wdata;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic set_tolerance(input logic [nrb_pkg::TOL_W-1:0] value);
		logic [31:0] rd;
		apb_cycle(1'b1, 32'(value), rd);
		tol_setting = value;
		apb_cycle(1'b0, 32'd0, rd);
		if (rd !== 32'(value))
			flag_mismatch($sformatf("tolerance readback exp %0d got %0d", value, rd));
	endtask

	// offer one word; called and returns at a falling edge
	task automatic offer_word(input logic signed [nrb_pkg::DATA_W-1:0] rad,
			input logic [nrb_pkg::INDEX_W-1:0] idx, input bit fixed, input root_word_t want);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			req_if.valid = 0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid = 1;
		req_if.radicand = rad;
		req_if.root_index = idx;
		do @(posedge clk); while (!req_if.ready);
		pending_roots.push_back(fixed ? want : bisect_root(rad, idx, tol_setting));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic offer_random_word();
		int          kind;
		int          nbits;
		logic [31:0] mag;
		logic [3:0]  idx;
		bit          negate;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			offer_word($urandom, 4'($urandom_range(0, 15)), 1'b0, '0);
		end else if (kind == 2) begin
			// magnitudes around one
			mag = 32'h0000_FFFF + 32'($urandom_range(0, 2));
			offer_word($urandom_range(0, 1) ? -mag : mag, 4'($urandom_range(0, 15)), 1'b0, '0);
		end else begin
			idx = 4'($urandom_range(2, 15));
			nbits = $urandom_range(17, 31);
			mag = ($urandom & ((32'd1 << nbits) - 32'd1)) | (32'd1 << (nbits - 1));
			negate = idx[0] && $urandom_range(0, 1);
			offer_word(negate ? -mag : mag, idx, 1'b0, '0);
		end
	endtask

	// wait for every outstanding word, then settle; returns at a falling edge
	task automatic drain_results(input int settle);
		req_if.valid = 0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
		@(negedge clk);
	endtask

	// result side
	initial begin
		int         stall;
		root_word_t got;
		root_word_t want;
		rsp_if.ready = 0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && words_back >= HOLD_AT) begin
				stall = HOLD_CYCLES;
				hold_done = 1;
			end else begin
				stall = draw_gap(recv_quiet);
			end
			@(negedge clk);
			if (stall > 0) begin
				rsp_if.ready = 0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1;
			do @(posedge clk); while (!rsp_if.valid);
			got.root = rsp_if.root;
			got.status = rsp_if.status;
			words_back++;
			case (got.status)
				nrb_pkg::ST_OK:      n_converged++;
				nrb_pkg::ST_INVALID: n_invalid++;
				default:             n_limit++;
			endcase
			if (pending_roots.size() == 0) begin
				flag_mismatch($sformatf("unexpected word root %h status %0d", got.root,
					got.status));
			end else begin
				want = pending_roots.pop_front();
				if (got.root !== want.root)
					flag_mismatch($sformatf("root exp %h got %h", want.root, got.root));
				if (got.status !== want.status)
					flag_mismatch($sformatf("status exp %0d got %0d (root %h)", want.status,
						got.status, want.root));
			end
		end
	end

	initial begin
		logic [nrb_pkg::TOL_W-1:0] phase_tol [N_PHASES];
		logic [31:0]               rd;
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 0;
		req_if.radicand = '0;
		req_if.root_index = '0;
		tol_setting = nrb_pkg::TOL_RESET;
		cycle_count = 0;
		mismatches = 0;
		words_sent = 0;
		words_back = 0;
		n_converged = 0;
		n_invalid = 0;
		n_limit = 0;
		send_quiet = 0;
		recv_quiet = 0;
		hold_done = 0;
		phase_tol = '{16'hFFFF, 16'd0, 16'd1, nrb_pkg::TOL_W'($urandom_range(2, 65534)),
			nrb_pkg::TOL_W'($urandom_range(2, 65534)), nrb_pkg::TOL_RESET};

		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		apb_cycle(1'b0, 32'd0, rd);
		if (rd !== 32'(nrb_pkg::TOL_RESET))
			flag_mismatch($sformatf("tolerance after reset exp %0d got %0d",
				nrb_pkg::TOL_RESET, rd));

		foreach (directed_rows[r])
			offer_word(directed_rows[r].radicand, directed_rows[r].index,
				directed_rows[r].fixed, directed_rows[r].want);
		drain_results(8);

		for (int p = 0; p < N_PHASES; p++) begin
			set_tolerance(phase_tol[p]);
			repeat (RANDOM_PER_PHASE) offer_random_word();
			drain_results(8);
		end

		drain_results(IDLE_WAIT);
		if (pending_roots.size() != 0)
			flag_mismatch($sformatf("%0d expected words never arrived", pending_roots.size()));

		$display("Sent %0d words (%0d directed) over %0d tolerance settings, with one %0d-cycle",
			words_sent, N_DIRECTED, N_PHASES + 1, HOLD_CYCLES);
		$display("output hold-off; results: %0d converged, %0d invalid, %0d at iteration limit",
			n_converged, n_invalid, n_limit);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
